>>> rtl/phlp_pkg.sv
// ----------------------------------------------------------------------------
// phlp_pkg
// Shared constants and types for the packet header layer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phlp_pkg;

  localparam int unsigned LengthBits = 16;
  localparam logic [LengthBits-1:0] CountMax = {LengthBits{1'b1}};

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;
  localparam logic [15:0] EtherTypeArp  = 16'h0806;

  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  localparam logic [6:0] EthHdrLen  = 7'd14;
  localparam logic [5:0] TcpHdrLen  = 6'd20;
  localparam logic [5:0] UdpHdrLen  = 6'd8;
  localparam logic [5:0] IcmpHdrLen = 6'd8;
  localparam logic [5:0] Ipv6HdrLen = 6'd40;
  localparam logic [5:0] ArpHdrLen  = 6'd28;
  localparam logic [6:0] Ipv6L4Off  = 7'd54;

  typedef enum logic [3:0] {
    RecEth     = 4'd0,
    RecIpv4    = 4'd1,
    RecIpv6    = 4'd2,
    RecTcp     = 4'd3,
    RecUdp     = 4'd4,
    RecIcmp    = 4'd5,
    RecArp     = 4'd7,
    RecUnknown = 4'd15
  } rec_type_e;

  typedef struct packed {
    rec_type_e  rtype;
    logic [6:0] offset;
    logic [5:0] length;
    logic       too_short;
  } record_t;

endpackage

`default_nettype wire

>>> rtl/packet_header_layer_parser_unit.sv
// ----------------------------------------------------------------------------
// packet_header_layer_parser_unit
// Byte-serial Ethernet/IP/L4 header locator emitting per-frame header records.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per request, end_of_frame_i on the final byte.
// Output channel: header records (type, offset, length) in layer order, up to
// three per frame, last_record_o set on the final one.
// The records of a frame are built in the cycle its final byte is taken and
// appear in the next cycle, one record per cycle while the receiver is ready.
// A single record set register holds one frame's records; a final byte is
// held off only while a previous frame still has records beyond the one being
// taken this cycle. Non-final bytes are always taken.
// When the receiver stalls, the current record holds and the set register
// stays full; bytes keep flowing until the next frame end.
// Reset clears the byte counter, the captured header fields and the count and
// valid flag of the record set, so the output channel comes up empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_header_layer_parser_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] frame_byte_i,
  input  wire logic       end_of_frame_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      record_type_o,
  output logic [6:0]      record_offset_o,
  output logic [5:0]      record_length_o,
  output logic            frame_too_short_o,
  output logic            last_record_o
);
  import phlp_pkg::*;

  logic [LengthBits-1:0] pos_q, pos_d, flen;
  logic [15:0] ether_type_q, ether_type_d;
  logic [7:0]  ip_first_q, ip_first_d;
  logic [7:0]  v6_next_q, v6_next_d;
  logic [7:0]  v4_proto_q, v4_proto_d;

  record_t     rec_q [3];
  record_t     rec_d [3];
  record_t     new_rec [3];
  logic [1:0]  cnt_q, cnt_d, new_cnt;
  logic        set_valid_q, set_valid_d;

  logic        in_fire, out_fire, set_free, load;
  logic [5:0]  ihl;
  logic [6:0]  l4_off;
  logic [LengthBits-1:0] l4_off_ext;

  assign out_fire   = set_valid_q && out_ready_i;
  assign set_free   = !set_valid_q || (out_ready_i && cnt_q == 2'd1);
  assign in_ready_o = !end_of_frame_i || set_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = in_fire && end_of_frame_i;

  // frame length including the byte being taken, saturating
  assign flen = (pos_q == CountMax) ? pos_q : pos_q + 1'b1;

  always_comb begin
    pos_d        = pos_q;
    ether_type_d = ether_type_q;
    ip_first_d   = ip_first_q;
    v6_next_d    = v6_next_q;
    v4_proto_d   = v4_proto_q;
    if (in_fire) begin
      if (end_of_frame_i) begin
        pos_d        = '0;
        ether_type_d = '0;
        ip_first_d   = '0;
        v6_next_d    = '0;
        v4_proto_d   = '0;
      end else begin
        pos_d = flen;
        if (pos_q == LengthBits'(12)) ether_type_d[15:8] = frame_byte_i;
        if (pos_q == LengthBits'(13)) ether_type_d[7:0] = frame_byte_i;
        if (pos_q == LengthBits'(14)) ip_first_d = frame_byte_i;
        if (pos_q == LengthBits'(20)) v6_next_d = frame_byte_i;
        if (pos_q == LengthBits'(23)) v4_proto_d = frame_byte_i;
      end
    end
  end

  assign ihl        = {ip_first_q[3:0], 2'b00};
  assign l4_off     = EthHdrLen + {1'b0, ihl};
  assign l4_off_ext = LengthBits'(l4_off);

  // record set for a frame ending now; captured fields at the final byte
  // never change the outcome, so the registered copies are used
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      new_rec[i] = '{rtype: RecUnknown, offset: '0, length: '0, too_short: 1'b0};
    end
    new_cnt = 2'd1;
    if (flen < LengthBits'(EthHdrLen)) begin
      new_rec[0].too_short = 1'b1;
    end else begin
      new_rec[0] = '{rtype: RecEth, offset: '0, length: 6'(EthHdrLen), too_short: 1'b0};
      if (ether_type_q == EtherTypeIpv4 && flen >= LengthBits'(34)) begin
        if (ip_first_q[7:4] == 4'd4) begin
          new_rec[1] = '{rtype: RecIpv4, offset: EthHdrLen, length: ihl, too_short: 1'b0};
          new_cnt    = 2'd2;
          if (v4_proto_q == ProtoTcp && flen >= l4_off_ext + LengthBits'(TcpHdrLen)) begin
            new_rec[2] = '{rtype: RecTcp, offset: l4_off, length: TcpHdrLen,
                           too_short: 1'b0};
            new_cnt    = 2'd3;
          end else if (v4_proto_q == ProtoUdp &&
                       flen >= l4_off_ext + LengthBits'(UdpHdrLen)) begin
            new_rec[2] = '{rtype: RecUdp, offset: l4_off, length: UdpHdrLen,
                           too_short: 1'b0};
            new_cnt    = 2'd3;
          end else if (v4_proto_q == ProtoIcmp) begin
            new_rec[2] = '{rtype: RecIcmp, offset: l4_off, length: IcmpHdrLen,
                           too_short: 1'b0};
            new_cnt    = 2'd3;
          end
        end
      end else if (ether_type_q == EtherTypeIpv6 && flen >= LengthBits'(54)) begin
        new_rec[1] = '{rtype: RecIpv6, offset: EthHdrLen, length: Ipv6HdrLen,
                       too_short: 1'b0};
        new_cnt    = 2'd2;
        if (v6_next_q == ProtoTcp && flen >= LengthBits'(74)) begin
          new_rec[2] = '{rtype: RecTcp, offset: Ipv6L4Off, length: TcpHdrLen,
                         too_short: 1'b0};
          new_cnt    = 2'd3;
        end else if (v6_next_q == ProtoUdp && flen >= LengthBits'(62)) begin
          new_rec[2] = '{rtype: RecUdp, offset: Ipv6L4Off, length: UdpHdrLen,
                         too_short: 1'b0};
          new_cnt    = 2'd3;
        end
      end else if (ether_type_q == EtherTypeArp && flen >= LengthBits'(42)) begin
        new_rec[1] = '{rtype: RecArp, offset: EthHdrLen, length: ArpHdrLen,
                       too_short: 1'b0};
        new_cnt    = 2'd2;
      end
    end
  end

  // record set: load on frame end, shift down as records drain
  always_comb begin
    rec_d       = rec_q;
    cnt_d       = cnt_q;
    set_valid_d = set_valid_q;
    if (load) begin
      rec_d       = new_rec;
      cnt_d       = new_cnt;
      set_valid_d = 1'b1;
    end else if (out_fire) begin
      rec_d[0] = rec_q[1];
      rec_d[1] = rec_q[2];
      cnt_d    = cnt_q - 2'd1;
      if (cnt_q == 2'd1) begin
        set_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ether_type_q <= '0;
      ip_first_q   <= '0;
      v6_next_q    <= '0;
      v4_proto_q   <= '0;
      cnt_q        <= '0;
      set_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      ether_type_q <= ether_type_d;
      ip_first_q   <= ip_first_d;
      v6_next_q    <= v6_next_d;
      v4_proto_q   <= v4_proto_d;
      cnt_q        <= cnt_d;
      set_valid_q  <= set_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign out_valid_o       = set_valid_q;
  assign record_type_o     = rec_q[0].rtype;
  assign record_offset_o   = rec_q[0].offset;
  assign record_length_o   = rec_q[0].length;
  assign frame_too_short_o = rec_q[0].too_short;
  assign last_record_o     = (cnt_q == 2'd1);

endmodule

`default_nettype wire

>>> bench/packet_header_layer_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// packet_header_layer_parser_unit_tb
// Self-checking bench for the byte-serial Ethernet/IP/L4 header locator.
// Frames are pushed one byte per request with random bursts and gaps. A
// behavioral parser in the bench predicts the header records of every frame,
// and each record taken from the output channel is compared with the oldest
// prediction while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_header_layer_parser_unit_tb;
  import phlp_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned MinIpv4Len   = 34;   // Ethernet plus a minimal IPv4 header
  localparam int unsigned RandRecords  = 60;
  localparam int unsigned RandBytes    = 100;
  localparam int unsigned LongFrameLen = 65540;

  typedef struct {
    rec_type_e  rtype;
    logic [6:0] off;
    logic [5:0] len;
    logic       short_f;
    logic       last;
  } hdr_rec_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] frame_byte_i = 8'h00;
  logic       end_of_frame_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] record_type_o;
  logic [6:0] record_offset_o;
  logic [5:0] record_length_o;
  logic       frame_too_short_o;
  logic       last_record_o;

  packet_header_layer_parser_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_byte_i     (frame_byte_i),
    .end_of_frame_i   (end_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .record_type_o    (record_type_o),
    .record_offset_o  (record_offset_o),
    .record_length_o  (record_length_o),
    .frame_too_short_o(frame_too_short_o),
    .last_record_o    (last_record_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parser state mirrored in the bench
  logic [LengthBits-1:0] byte_count = '0;
  logic [15:0]           ethertype_seen = '0;
  logic [7:0]            ip_byte0 = '0;
  logic [7:0]            v6_next_hdr = '0;
  logic [7:0]            v4_proto = '0;

  hdr_rec_t    pending_records[$];
  hdr_rec_t    want_rec;
  int unsigned mismatch_count = 0;
  int unsigned records_predicted = 0;
  int unsigned records_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  function automatic hdr_rec_t hdr(input rec_type_e t, input int unsigned off,
                                   input int unsigned len);
    hdr_rec_t r;
    r.rtype   = t;
    r.off     = off[6:0];
    r.len     = len[5:0];
    r.short_f = 1'b0;
    r.last    = 1'b0;
    return r;
  endfunction

  // Capture one byte; at frame end append the frame's header records.
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    hdr_rec_t    recs[$];
    hdr_rec_t    r;
    int unsigned flen;
    int unsigned ihl;
    int unsigned l4_off;
    case (byte_count)
      12: ethertype_seen[15:8] = b;
      13: ethertype_seen[7:0] = b;
      14: ip_byte0 = b;
      20: v6_next_hdr = b;
      23: v4_proto = b;
      default: ;
    endcase
    if (byte_count != CountMax) byte_count = byte_count + 1'b1;
    if (eof) begin
      flen = 32'(byte_count);
      if (flen < EthHdrLen) begin
        r = hdr(RecUnknown, 0, 0);
        r.short_f = 1'b1;
        recs.push_back(r);
      end else begin
        recs.push_back(hdr(RecEth, 0, EthHdrLen));
        if (ethertype_seen == EtherTypeIpv4 && flen >= MinIpv4Len) begin
          if (ip_byte0[7:4] == 4'd4) begin
            ihl = ip_byte0[3:0] * 4;
            l4_off = EthHdrLen + ihl;
            recs.push_back(hdr(RecIpv4, EthHdrLen, ihl));
            if (v4_proto == ProtoTcp && flen >= l4_off + TcpHdrLen)
              recs.push_back(hdr(RecTcp, l4_off, TcpHdrLen));
            else if (v4_proto == ProtoUdp && flen >= l4_off + UdpHdrLen)
              recs.push_back(hdr(RecUdp, l4_off, UdpHdrLen));
            else if (v4_proto == ProtoIcmp)
              recs.push_back(hdr(RecIcmp, l4_off, IcmpHdrLen));  // no length check
          end
        end else if (ethertype_seen == EtherTypeIpv6 && flen >= EthHdrLen + Ipv6HdrLen) begin
          recs.push_back(hdr(RecIpv6, EthHdrLen, Ipv6HdrLen));
          if (v6_next_hdr == ProtoTcp && flen >= Ipv6L4Off + TcpHdrLen)
            recs.push_back(hdr(RecTcp, Ipv6L4Off, TcpHdrLen));
          else if (v6_next_hdr == ProtoUdp && flen >= Ipv6L4Off + UdpHdrLen)
            recs.push_back(hdr(RecUdp, Ipv6L4Off, UdpHdrLen));
        end else if (ethertype_seen == EtherTypeArp && flen >= EthHdrLen + ArpHdrLen) begin
          recs.push_back(hdr(RecArp, EthHdrLen, ArpHdrLen));
        end
      end
      recs[recs.size()-1].last = 1'b1;
      foreach (recs[i]) pending_records.push_back(recs[i]);
      records_predicted += recs.size();
      byte_count = '0;
      ethertype_seen = '0;
      ip_byte0 = '0;
      v6_next_hdr = '0;
      v4_proto = '0;
    end
  endtask

  // One request on the input channel; called right after a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i     <= 1'b1;
    frame_byte_i   <= b;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input logic [15:0] etype,
                            input logic [7:0] b14, input logic [7:0] b20,
                            input logic [7:0] b23);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      case (i)
        12: b = etype[15:8];
        13: b = etype[7:0];
        14: b = b14;
        20: b = b20;
        23: b = b23;
        default: ;
      endcase
      send_byte(b, i == len - 1);
    end
    frames_sent++;
  endtask

  // Hold the sender until every predicted record has been taken.
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_records.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s got %0h want %0h",
                                records_checked, name, got, want));
  endtask

  // receiver: the mode is redrawn at random whenever the low six bits of rx_tick are zero
  logic [7:0] rx_tick = '0;
  logic [1:0] rx_mode = '0;
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i <= (rx_tick[2:0] < 3'd3);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record type %0h offset %0d",
                                  record_type_o, record_offset_o));
      end else begin
        want_rec = pending_records.pop_front();
        check_field("type", {4'd0, record_type_o}, {4'd0, want_rec.rtype});
        check_field("offset", {1'b0, record_offset_o}, {1'b0, want_rec.off});
        check_field("length", {2'd0, record_length_o}, {2'd0, want_rec.len});
        check_field("too_short", {7'd0, frame_too_short_o}, {7'd0, want_rec.short_f});
        check_field("last", {7'd0, last_record_o}, {7'd0, want_rec.last});
        records_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && pending_records.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no progress for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_short_frames;
    gaps_on = 1'b1;
    send_frame(1, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_frame(13, EtherTypeIpv4, 8'h45, 8'h00, ProtoTcp);
    send_frame(14, EtherTypeIpv4, 8'h45, 8'h00, ProtoTcp);
    drain();
  endtask

  task automatic test_ipv4_frames;
    send_frame(54, EtherTypeIpv4, 8'h45, 8'h00, ProtoTcp);
    send_frame(53, EtherTypeIpv4, 8'h45, 8'h00, ProtoTcp);
    send_frame(42, EtherTypeIpv4, 8'h45, 8'hff, ProtoUdp);
    send_frame(41, EtherTypeIpv4, 8'h45, 8'hff, ProtoUdp);
    send_frame(34, EtherTypeIpv4, 8'h45, 8'h00, ProtoIcmp);
    send_frame(33, EtherTypeIpv4, 8'h45, 8'h00, ProtoTcp);
    send_frame(60, EtherTypeIpv4, 8'h65, 8'h00, ProtoTcp);   // wrong version
    send_frame(94, EtherTypeIpv4, 8'h4f, 8'h00, ProtoTcp);   // max IHL
    send_frame(34, EtherTypeIpv4, 8'h40, 8'h00, ProtoTcp);   // zero IHL
    send_frame(60, EtherTypeIpv4, 8'h45, 8'h00, 8'hff);      // unknown protocol
    drain();
  endtask

  task automatic test_ipv6_frames;
    send_frame(74, EtherTypeIpv6, 8'h60, ProtoTcp, 8'h00);
    send_frame(73, EtherTypeIpv6, 8'h60, ProtoTcp, 8'h00);
    send_frame(62, EtherTypeIpv6, 8'h60, ProtoUdp, 8'h00);
    send_frame(54, EtherTypeIpv6, 8'h60, 8'h3a, 8'h00);
    send_frame(53, EtherTypeIpv6, 8'h60, ProtoUdp, 8'h00);
    drain();
  endtask

  task automatic test_arp_frames;
    send_frame(42, EtherTypeArp, 8'h00, 8'h00, 8'h00);
    send_frame(41, EtherTypeArp, 8'h00, 8'h00, 8'h00);
    drain();
  endtask

  // single-byte frames back to back push on the record set hold-off
  task automatic test_back_to_back;
    gaps_on = 1'b0;
    repeat (3) send_frame(1, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_frame(14, 16'hffff, 8'hff, 8'hff, 8'hff);
    drain();
  endtask

  task automatic test_long_frame;
    gaps_on = 1'b0;
    send_frame(LongFrameLen, EtherTypeIpv4, 8'h45, 8'h00, ProtoUdp);
    drain();
  endtask

  task automatic test_random_frames;
    int unsigned start_recs;
    int unsigned start_bytes;
    int unsigned kind;
    int unsigned base;
    int unsigned len;
    logic [15:0] etype;
    logic [7:0]  b14;
    logic [7:0]  b20;
    logic [7:0]  b23;
    start_recs  = records_predicted;
    start_bytes = bytes_sent;
    while (records_predicted - start_recs < RandRecords ||
           bytes_sent - start_bytes < RandBytes) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      b14 = 8'($urandom_range(0, 255));
      b20 = 8'($urandom_range(0, 255));
      b23 = 8'($urandom_range(0, 255));
      etype = 16'($urandom_range(0, 65535));
      // at least 3 so the straddle below never drops under one byte
      base = $urandom_range(3, 90);
      case (kind)
        0, 1, 2, 8: begin
          etype = EtherTypeIpv4;
          if (kind != 8 && $urandom_range(0, 3) != 0)
            b14 = {4'd4, ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom_range(0, 15))};
          case ($urandom_range(0, 3))
            0: b23 = ProtoTcp;
            1: b23 = ProtoUdp;
            2: b23 = ProtoIcmp;
            default: ;
          endcase
          base = EthHdrLen + b14[3:0] * 4 + ((b23 == ProtoTcp) ? TcpHdrLen : UdpHdrLen);
          if (kind == 8 || base < MinIpv4Len) base = MinIpv4Len;
        end
        3, 4: begin
          etype = EtherTypeIpv6;
          case ($urandom_range(0, 2))
            0: b20 = ProtoTcp;
            1: b20 = ProtoUdp;
            default: ;
          endcase
          base = Ipv6L4Off + ((b20 == ProtoTcp) ? TcpHdrLen : UdpHdrLen);
        end
        5: base = EthHdrLen + ArpHdrLen;
        7: base = $urandom_range(3, 15);
        default: ;
      endcase
      if (kind == 5) etype = EtherTypeArp;
      // mostly straddle the length threshold, sometimes well past it
      if ($urandom_range(0, 3) != 0) len = base + $urandom_range(0, 4) - 2;
      else len = base + $urandom_range(0, 20);
      send_frame(len, etype, b14, b20, b23);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_frames();
    test_ipv4_frames();
    test_ipv6_frames();
    test_arp_frames();
    test_back_to_back();
    test_long_frame();
    test_random_frames();
    $display("covered %0d frames, %0d bytes, %0d header records checked",
             frames_sent, bytes_sent, records_checked);
    $display("includes short, IPv4/IPv6/ARP threshold and saturated-count frames");
    if (mismatch_count == 0 && pending_records.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/phlp_pkg.sv
rtl/packet_header_layer_parser_unit.sv
bench/packet_header_layer_parser_unit_tb.sv
